// ===== rtl/ipv4bl_pkg.sv =====
package ipv4bl_pkg;

	localparam int TABLE_ENTRIES   = 16;
	localparam int IDX_W           = 4;
	localparam int MAX_FRAME_BYTES = 16383;
	localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);
	localparam int CNT_W           = 64;

	localparam int ETH_HDR_BYTES   = 14;
	localparam int IPV4_MIN_END    = 34;
	localparam int ETYPE_HI_POS    = 12;
	localparam int ETYPE_LO_POS    = 13;
	localparam int SRC_FIRST_POS   = 26;
	localparam int SRC_LAST_POS    = 29;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

	localparam logic MODE_FRAME = 1'b0;
	localparam logic MODE_ENTRY = 1'b1;

	typedef enum logic [1:0] {
		VERDICT_PASS  = 2'd0,
		VERDICT_DROP  = 2'd1,
		VERDICT_ABORT = 2'd2
	} verdict_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [31:0]      addr;
		logic             valid;
		logic             counting;
	} entry_wr_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] idx;
		logic             counting;
	} match_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] idx;
		logic             count;
		logic [POS_W-1:0] blen;
	} stats_upd_t;

endpackage

// ===== rtl/ipv4bl_table.sv =====
module ipv4bl_table import ipv4bl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  entry_wr_t   wr,
	input  logic [31:0] lookup_addr,
	output match_t      match
);

	logic [31:0]              addr_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [TABLE_ENTRIES-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				addr_q[i] <= '0;
			end
		end else if (wr.en) begin
			// every 4-bit slot index names exactly one of the TABLE_ENTRIES slots
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (wr.idx == IDX_W'(i)) begin
					addr_q[i]  <= wr.addr;
					valid_q[i] <= wr.valid;
					count_q[i] <= wr.counting;
				end
			end
		end
	end

	// parallel compare, walked downward so the lowest slot wins
	always_comb begin
		match = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && addr_q[i] == lookup_addr) begin
				match.hit      = 1'b1;
				match.idx      = IDX_W'(i);
				match.counting = count_q[i];
			end
		end
	end

endmodule

// ===== rtl/ipv4bl_stats.sv =====
module ipv4bl_stats import ipv4bl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr_en,
	input  logic [IDX_W-1:0] clr_idx,
	input  logic             upd_en,
	input  stats_upd_t       upd,
	output logic [CNT_W-1:0] packet_count,
	output logic [CNT_W-1:0] byte_count
);

	logic [CNT_W-1:0] pkts_q [TABLE_ENTRIES];
	logic [CNT_W-1:0] bytes_q [TABLE_ENTRIES];
	logic [CNT_W-1:0] pkts_new;
	logic [CNT_W-1:0] bytes_new;

	always_comb begin
		pkts_new  = pkts_q[upd.idx] + CNT_W'(upd.count);
		bytes_new = bytes_q[upd.idx] + (upd.count ? CNT_W'(upd.blen) : '0);
		packet_count = upd.hit ? pkts_new : '0;
		byte_count   = upd.hit ? bytes_new : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				pkts_q[i]  <= '0;
				bytes_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				// the entry write is the younger item, so its clear wins
				if (clr_en && clr_idx == IDX_W'(i)) begin
					pkts_q[i]  <= '0;
					bytes_q[i] <= '0;
				end else if (upd_en && upd.count && upd.idx == IDX_W'(i)) begin
					pkts_q[i]  <= pkts_new;
					bytes_q[i] <= bytes_new;
				end
			end
		end
	end

endmodule

// ===== rtl/ipv4_source_blocklist_filter.sv =====
// IPv4 source blocklist filter. Takes one item per clock while in_ready is high:
// a frame byte (mode 0) or a blocklist slot write (mode 1). On the last byte of
// a frame it returns one verdict (pass, drop, or abort for runts), with the
// matched slot and that slot's packet and byte counters after the update; other
// items return nothing. The block sustains one item per cycle, unless the output
// stalls, through three register stages (input, slot match, counter update),
// which each verdict passes in turn. in_ready follows out_ready combinationally:
// while a result waits at the output with out_ready low, the whole pipe holds.
// Slot writes clear that slot's counters and take effect for every later item.
module ipv4_source_blocklist_filter import ipv4bl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              mode,
	input  logic [7:0]        frame_byte,
	input  logic              frame_last,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic [31:0]       entry_address,
	input  logic              entry_valid,
	input  logic              entry_counting,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        verdict,
	output logic              hit,
	output logic [IDX_W-1:0]  hit_index,
	output logic              stats_updated,
	output logic [CNT_W-1:0]  packet_count,
	output logic [CNT_W-1:0]  byte_count
);

	logic adv;

	// input stage
	logic             v_s1;
	logic             mode_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [31:0]      addr_s1;
	logic             ent_valid_s1;
	logic             ent_cnt_s1;

	// frame capture state
	logic [POS_W-1:0] pos_q;
	logic [15:0]      ether_q;
	logic [31:0]      src_q;

	logic [15:0]      ether_nx;
	logic [31:0]      src_nx;
	logic [POS_W-1:0] len;
	logic             frame_s1;
	logic             res_nx;
	logic             compare_nx;
	verdict_t         verdict_nx;
	entry_wr_t        wr;
	match_t           match;

	// match stage
	logic             res_s2;
	verdict_t         verdict_s2;
	match_t           match_s2;
	logic [POS_W-1:0] blen_s2;
	stats_upd_t       upd;
	logic [CNT_W-1:0] pkts_new;
	logic [CNT_W-1:0] bytes_new;

	// output register
	logic             out_valid_q;
	verdict_t         verdict_q;
	logic             hit_q;
	logic [IDX_W-1:0] hidx_q;
	logic             upd_q;
	logic [CNT_W-1:0] pkts_q;
	logic [CNT_W-1:0] bytes_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			mode_s1      <= mode;
			byte_s1      <= frame_byte;
			last_s1      <= frame_last;
			idx_s1       <= entry_index;
			addr_s1      <= entry_address;
			ent_valid_s1 <= entry_valid;
			ent_cnt_s1   <= entry_counting;
		end
	end

	assign frame_s1 = v_s1 && (mode_s1 == MODE_FRAME);

	always_comb begin
		ether_nx = ether_q;
		src_nx   = src_q;
		if (pos_q == POS_W'(ETYPE_HI_POS)) begin
			ether_nx = {byte_s1, ether_q[7:0]};
		end else if (pos_q == POS_W'(ETYPE_LO_POS)) begin
			ether_nx = {ether_q[15:8], byte_s1};
		end else if (pos_q >= POS_W'(SRC_FIRST_POS) && pos_q <= POS_W'(SRC_LAST_POS)) begin
			src_nx = {src_q[23:0], byte_s1};
		end
		len = (pos_q < POS_W'(MAX_FRAME_BYTES)) ? pos_q + 1'b1 : POS_W'(MAX_FRAME_BYTES);
	end

	always_comb begin
		compare_nx = 1'b0;
		if (len < POS_W'(ETH_HDR_BYTES)) begin
			verdict_nx = VERDICT_ABORT;
		end else if (ether_nx != ETHERTYPE_IPV4) begin
			verdict_nx = VERDICT_PASS;
		end else if (len < POS_W'(IPV4_MIN_END)) begin
			verdict_nx = VERDICT_ABORT;
		end else begin
			compare_nx = 1'b1;
			verdict_nx = match.hit ? VERDICT_DROP : VERDICT_PASS;
		end
	end

	assign res_nx = frame_s1 && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			ether_q <= '0;
			src_q   <= '0;
		end else if (adv && frame_s1) begin
			if (last_s1) begin
				pos_q   <= '0;
				ether_q <= '0;
				src_q   <= '0;
			end else begin
				pos_q   <= len;
				ether_q <= ether_nx;
				src_q   <= src_nx;
			end
		end
	end

	always_comb begin
		wr.en       = adv && v_s1 && (mode_s1 == MODE_ENTRY);
		wr.idx      = idx_s1;
		wr.addr     = addr_s1;
		wr.valid    = ent_valid_s1;
		wr.counting = ent_cnt_s1;
	end

	ipv4bl_table u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (wr),
		.lookup_addr (src_nx),
		.match       (match)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= 1'b0;
		end else if (adv) begin
			res_s2 <= res_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_nx) begin
			verdict_s2 <= verdict_nx;
			match_s2   <= compare_nx ? match : '0;
			blen_s2    <= len - POS_W'(ETH_HDR_BYTES);
		end
	end

	always_comb begin
		upd.hit   = match_s2.hit;
		upd.idx   = match_s2.idx;
		upd.count = match_s2.hit && match_s2.counting;
		upd.blen  = blen_s2;
	end

	ipv4bl_stats u_stats (
		.clk          (clk),
		.arst_n       (arst_n),
		.clr_en       (wr.en),
		.clr_idx      (idx_s1),
		.upd_en       (adv && res_s2),
		.upd          (upd),
		.packet_count (pkts_new),
		.byte_count   (bytes_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_s2) begin
			verdict_q <= verdict_s2;
			hit_q     <= upd.hit;
			hidx_q    <= upd.idx;
			upd_q     <= upd.count;
			pkts_q    <= pkts_new;
			bytes_q   <= bytes_new;
		end
	end

	assign out_valid     = out_valid_q;
	assign verdict       = verdict_q;
	assign hit           = hit_q;
	assign hit_index     = hidx_q;
	assign stats_updated = upd_q;
	assign packet_count  = pkts_q;
	assign byte_count    = bytes_q;

	// counting only happens on a dropped frame
	assert property (@(posedge clk) disable iff (!arst_n)
		res_s2 && upd.count |-> upd.hit && verdict_s2 == VERDICT_DROP)
		else $error("stats update without a drop verdict");

	// a miss reports all-zero slot fields
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> hit_index == '0 && !stats_updated
			&& packet_count == '0 && byte_count == '0)
		else $error("slot fields set on a miss");

	// the end of a frame rewinds the capture state
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && frame_s1 && last_s1 |=> pos_q == '0 && ether_q == '0 && src_q == '0)
		else $error("capture state not cleared after last byte");

	// a stalled output freezes frame capture
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pos_q) && $stable(src_q))
		else $error("frame state moved during a stall");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb import ipv4bl_pkg::*;;

	localparam int RAND_ITEMS  = 900;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int DRAIN_WAIT  = 8;
	localparam int NUM_ROWS    = 26;

	typedef enum logic {ROW_ENTRY, ROW_FRAME} row_kind_t;

	typedef struct packed {
		logic             mode;
		logic [7:0]       data;
		logic             last;
		logic [IDX_W-1:0] idx;
		logic [31:0]      addr;
		logic             on;
		logic             counting;
		logic             fixed;
		verdict_t         fv;
	} in_item_t;

	typedef struct packed {
		verdict_t         verdict;
		logic             hit;
		logic [IDX_W-1:0] idx;
		logic             upd;
		logic [CNT_W-1:0] pk;
		logic [CNT_W-1:0] by;
	} filt_res_t;

	typedef struct {
		row_kind_t        kind;
		int               flen;
		logic [15:0]      etype;
		logic [31:0]      src;
		int               mid_at;
		logic [IDX_W-1:0] idx;
		logic [31:0]      addr;
		logic             on;
		logic             counting;
		logic             fixed;
		verdict_t         fv;
	} plan_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             mode = MODE_FRAME;
	logic [7:0]       frame_byte = '0;
	logic             frame_last = 1'b0;
	logic [IDX_W-1:0] entry_index = '0;
	logic [31:0]      entry_address = '0;
	logic             entry_valid = 1'b0;
	logic             entry_counting = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [1:0]       verdict;
	logic             hit;
	logic [IDX_W-1:0] hit_index;
	logic             stats_updated;
	logic [CNT_W-1:0] packet_count;
	logic [CNT_W-1:0] byte_count;

	// typed expectation riding along with the item on the input
	logic             cur_fixed = 1'b0;
	verdict_t         cur_fv = VERDICT_PASS;

	// predictor copy of the blocklist and the frame being parsed
	bit [31:0]        bl_addr  [TABLE_ENTRIES];
	bit               bl_on    [TABLE_ENTRIES];
	bit               bl_stats [TABLE_ENTRIES];
	bit [CNT_W-1:0]   bl_pkts  [TABLE_ENTRIES];
	bit [CNT_W-1:0]   bl_bytes [TABLE_ENTRIES];
	bit [POS_W-1:0]   fr_len;
	bit [15:0]        fr_etype;
	bit [31:0]        fr_src;

	filt_res_t        verdict_q [$];
	bit [31:0]        gen_addr [TABLE_ENTRIES];

	int snd_idle = 19;
	int rcv_idle = 88;
	int cycles = 0;
	int mismatch_cnt = 0;
	int items_sent = 0;
	int frames_sent = 0;
	int n_writes = 0;
	int n_pass = 0;
	int n_drop = 0;
	int n_abort = 0;
	int n_upd = 0;

	plan_row_t plan [NUM_ROWS] = '{
		'{ROW_FRAME, 34, 16'h0800, 32'h0000_0000, -1, 4'd0, 32'h0, 1'b0, 1'b0, 1'b1, VERDICT_PASS},
		'{ROW_FRAME, 1, 16'h0800, 32'h0000_0000, -1, 4'd0, 32'h0, 1'b0, 1'b0, 1'b1, VERDICT_ABORT},
		'{ROW_FRAME, 13, 16'h0800, 32'h0000_0000, -1, 4'd0, 32'h0, 1'b0, 1'b0, 1'b1, VERDICT_ABORT},
		'{ROW_FRAME, 14, 16'h86DD, 32'h0000_0000, -1, 4'd0, 32'h0, 1'b0, 1'b0, 1'b1, VERDICT_PASS},
		'{ROW_FRAME, 33, 16'h0800, 32'h0000_0000, -1, 4'd0, 32'h0, 1'b0, 1'b0, 1'b1, VERDICT_ABORT},
		'{ROW_FRAME, 20, 16'h0008, 32'h0000_0000, -1, 4'd0, 32'h0, 1'b0, 1'b0, 1'b1, VERDICT_PASS},
		'{ROW_ENTRY, 0, 16'h0, 32'h0, -1, 4'd0, 32'hC0A8_0001, 1'b1, 1'b1, 1'b0, VERDICT_PASS},
		'{ROW_ENTRY, 0, 16'h0, 32'h0, -1, 4'd15, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ENTRY, 0, 16'h0, 32'h0, -1, 4'd5, 32'hC0A8_0001, 1'b1, 1'b1, 1'b0, VERDICT_PASS},
		'{ROW_FRAME, 34, 16'h0800, 32'hC0A8_0001, -1, 4'd0, 32'h0, 1'b0, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_FRAME, 60, 16'h0800, 32'hFFFF_FFFF, -1, 4'd0, 32'h0, 1'b0, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_FRAME, 64, 16'h0800, 32'hC0A8_0001, -1, 4'd0, 32'h0, 1'b0, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ENTRY, 0, 16'h0, 32'h0, -1, 4'd0, 32'hC0A8_0001, 1'b0, 1'b1, 1'b0, VERDICT_PASS},
		'{ROW_FRAME, 40, 16'h0800, 32'hC0A8_0001, -1, 4'd0, 32'h0, 1'b0, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_FRAME, 34, 16'h0800, 32'h0000_0000, -1, 4'd0, 32'h0, 1'b0, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ENTRY, 0, 16'h0, 32'h0, -1, 4'd3, 32'h0000_0000, 1'b1, 1'b1, 1'b0, VERDICT_PASS},
		'{ROW_FRAME, 34, 16'h0800, 32'h0000_0000, -1, 4'd0, 32'h0, 1'b0, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_FRAME, 50, 16'h0800, 32'hFFFF_FFFF, 20, 4'd15, 32'hFFFF_FFFF, 1'b1, 1'b1,
			1'b0, VERDICT_PASS},
		'{ROW_FRAME, 40, 16'h0800, 32'h0A00_0001, 5, 4'd7, 32'h0A00_0001, 1'b1, 1'b1,
			1'b0, VERDICT_PASS},
		'{ROW_FRAME, 34, 16'h0800, 32'h0102_0304, 27, 4'd9, 32'h0102_0304, 1'b1, 1'b0,
			1'b0, VERDICT_PASS},
		'{ROW_ENTRY, 0, 16'h0, 32'h0, -1, 4'd1, 32'h7F00_0001, 1'b1, 1'b1, 1'b0, VERDICT_PASS},
		'{ROW_FRAME, 100, 16'h0800, 32'h7F00_0001, -1, 4'd0, 32'h0, 1'b0, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_FRAME, 34, 16'h0800, 32'h7F00_0001, -1, 4'd0, 32'h0, 1'b0, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_ENTRY, 0, 16'h0, 32'h0, -1, 4'd2, 32'h55AA_55AA, 1'b0, 1'b1, 1'b0, VERDICT_PASS},
		'{ROW_FRAME, 34, 16'h0800, 32'h55AA_55AA, -1, 4'd0, 32'h0, 1'b0, 1'b0, 1'b0, VERDICT_PASS},
		'{ROW_FRAME, 34, 16'h0801, 32'hC0A8_0001, -1, 4'd0, 32'h0, 1'b0, 1'b0, 1'b0, VERDICT_PASS}
	};

	ipv4_source_blocklist_filter dut (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= rcv_idle);
	end

	task automatic judge_item(input in_item_t it, output bit fresh, output filt_res_t r);
		int pos;
		int flen;
		fresh = 1'b0;
		r = '0;
		if (it.mode == MODE_ENTRY) begin
			bl_addr[it.idx] = it.addr;
			bl_on[it.idx] = it.on;
			bl_stats[it.idx] = it.counting;
			bl_pkts[it.idx] = '0;
			bl_bytes[it.idx] = '0;
			return;
		end
		pos = fr_len;
		if (pos == ETYPE_HI_POS)
			fr_etype[15:8] = it.data;
		else if (pos == ETYPE_LO_POS)
			fr_etype[7:0] = it.data;
		else if (pos >= SRC_FIRST_POS && pos <= SRC_LAST_POS)
			fr_src = {fr_src[23:0], it.data};
		flen = (pos < MAX_FRAME_BYTES) ? pos + 1 : MAX_FRAME_BYTES;
		fr_len = flen[POS_W-1:0];
		if (!it.last)
			return;
		fresh = 1'b1;
		if (flen < ETH_HDR_BYTES) begin
			r.verdict = VERDICT_ABORT;
		end else if (fr_etype != ETHERTYPE_IPV4) begin
			r.verdict = VERDICT_PASS;
		end else if (flen < IPV4_MIN_END) begin
			r.verdict = VERDICT_ABORT;
		end else begin
			// walk down so the lowest matching slot is the one kept
			for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
				if (bl_on[k] && bl_addr[k] == fr_src) begin
					r.hit = 1'b1;
					r.idx = k[IDX_W-1:0];
				end
			end
			if (r.hit) begin
				r.verdict = VERDICT_DROP;
				if (bl_stats[r.idx]) begin
					bl_pkts[r.idx] += CNT_W'(1);
					bl_bytes[r.idx] += CNT_W'(flen - ETH_HDR_BYTES);
					r.upd = 1'b1;
				end
				r.pk = bl_pkts[r.idx];
				r.by = bl_bytes[r.idx];
			end
		end
		fr_len = '0;
		fr_etype = '0;
		fr_src = '0;
	endtask

	always @(posedge clk) begin : track
		in_item_t  acc;
		filt_res_t want;
		bit        fresh;
		if (in_valid && in_ready) begin
			acc.mode = mode;
			acc.data = frame_byte;
			acc.last = frame_last;
			acc.idx = entry_index;
			acc.addr = entry_address;
			acc.on = entry_valid;
			acc.counting = entry_counting;
			acc.fixed = cur_fixed;
			acc.fv = cur_fv;
			judge_item(acc, fresh, want);
			if (fresh) begin
				if (acc.fixed) begin
					want = '0;
					want.verdict = acc.fv;
				end
				verdict_q.push_back(want);
			end
		end
		if (out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				$error("verdict returned with none expected");
				mismatch_cnt++;
			end else begin
				want = verdict_q.pop_front();
				if (verdict !== want.verdict) begin
					$error("verdict: expected %0d, actual %0d", want.verdict, verdict);
					mismatch_cnt++;
				end
				if (hit !== want.hit) begin
					$error("hit: expected %0d, actual %0d", want.hit, hit);
					mismatch_cnt++;
				end
				if (hit_index !== want.idx) begin
					$error("hit_index: expected %0d, actual %0d", want.idx, hit_index);
					mismatch_cnt++;
				end
				if (stats_updated !== want.upd) begin
					$error("stats_updated: expected %0d, actual %0d", want.upd, stats_updated);
					mismatch_cnt++;
				end
				if (packet_count !== want.pk) begin
					$error("packet_count: expected %0d, actual %0d", want.pk, packet_count);
					mismatch_cnt++;
				end
				if (byte_count !== want.by) begin
					$error("byte_count: expected %0d, actual %0d", want.by, byte_count);
					mismatch_cnt++;
				end
				case (want.verdict)
					VERDICT_PASS: n_pass++;
					VERDICT_DROP: n_drop++;
					default: n_abort++;
				endcase
				if (want.upd)
					n_upd++;
			end
		end
	end

	task automatic push_item(input in_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		mode <= it.mode;
		frame_byte <= it.data;
		frame_last <= it.last;
		entry_index <= it.idx;
		entry_address <= it.addr;
		entry_valid <= it.on;
		entry_counting <= it.counting;
		cur_fixed <= it.fixed;
		cur_fv <= it.fv;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		items_sent++;
		if (it.mode == MODE_ENTRY) begin
			gen_addr[it.idx] = it.addr;
			n_writes++;
		end
	endtask

	// wr is slipped in right after byte mid_at of the frame
	task automatic send_frame(input int flen, input logic [15:0] etype, input logic [31:0] src,
			input int mid_at, input in_item_t wr, input bit fixed, input verdict_t fv);
		in_item_t it;
		for (int p = 0; p < flen; p++) begin
			it.mode = MODE_FRAME;
			it.last = (p == flen - 1);
			it.idx = IDX_W'($urandom);
			it.addr = $urandom;
			it.on = 1'($urandom);
			it.counting = 1'($urandom);
			it.fixed = fixed && it.last;
			it.fv = fv;
			if (p == ETYPE_HI_POS)
				it.data = etype[15:8];
			else if (p == ETYPE_LO_POS)
				it.data = etype[7:0];
			else if (p >= SRC_FIRST_POS && p <= SRC_LAST_POS)
				it.data = src[8 * (SRC_LAST_POS - p) +: 8];
			else
				it.data = 8'($urandom);
			push_item(it);
			if (p == mid_at)
				push_item(wr);
		end
		frames_sent++;
	endtask

	task automatic rand_entry(output in_item_t it);
		it = '0;
		it.mode = MODE_ENTRY;
		it.data = 8'($urandom);
		it.last = 1'($urandom);
		it.idx = IDX_W'($urandom);
		// reuse addresses now and then so several slots hold the same one
		if ($urandom_range(1))
			it.addr = gen_addr[$urandom_range(TABLE_ENTRIES - 1)];
		else
			it.addr = $urandom;
		it.on = ($urandom_range(3) != 0);
		it.counting = 1'($urandom);
	endtask

	initial begin
		in_item_t    wr;
		int          first_item;
		int          done;
		int          pick;
		int          flen;
		int          mid_at;
		logic [15:0] etype;
		logic [31:0] src;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			wr = '0;
			wr.mode = MODE_ENTRY;
			wr.data = 8'($urandom);
			wr.last = 1'($urandom);
			wr.idx = plan[i].idx;
			wr.addr = plan[i].addr;
			wr.on = plan[i].on;
			wr.counting = plan[i].counting;
			if (plan[i].kind == ROW_ENTRY)
				push_item(wr);
			else
				send_frame(plan[i].flen, plan[i].etype, plan[i].src, plan[i].mid_at, wr,
					plan[i].fixed, plan[i].fv);
		end

		first_item = items_sent;
		done = 0;
		while (done < RAND_ITEMS) begin
			if (done >= 2 * RAND_ITEMS / 3) begin
				snd_idle = 0;
				rcv_idle = 0;
			end else if (done >= RAND_ITEMS / 3) begin
				snd_idle = 88;
				rcv_idle = 19;
			end
			if ($urandom_range(99) < 12) begin
				rand_entry(wr);
				push_item(wr);
			end else begin
				pick = $urandom_range(99);
				if (pick < 10)
					flen = $urandom_range(13, 1);
				else if (pick < 20)
					flen = $urandom_range(33, 14);
				else if (pick < 25)
					flen = $urandom_range(200, 34);
				else
					flen = $urandom_range(48, 34);
				etype = ($urandom_range(99) < 85) ? ETHERTYPE_IPV4 : 16'($urandom);
				if ($urandom_range(99) < 65)
					src = gen_addr[$urandom_range(TABLE_ENTRIES - 1)];
				else
					src = $urandom;
				rand_entry(wr);
				if ($urandom_range(99) < 15)
					mid_at = $urandom_range(flen - 1);
				else
					mid_at = -1;
				send_frame(flen, etype, src, mid_at, wr, 1'b0, VERDICT_PASS);
			end
			done = items_sent - first_item;
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d items accepted: %0d frames, %0d slot writes", items_sent, frames_sent,
			n_writes);
		$display("verdicts checked: %0d pass, %0d drop (%0d counted), %0d abort", n_pass,
			n_drop, n_upd, n_abort);
		if (mismatch_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
